FILE: design/mfvpt_pkg.sv
// package for the most frequent value pop table
// holds sizes, status and action codes, and the scan token and update types
// no dependencies
package mfvpt_pkg;

    localparam int ENTRIES    = 64;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POPPED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef enum logic [1:0] {
        UPD_NEW,
        UPD_INC,
        UPD_CLR
    } t_upd_kind;

    // token that walks the chain, one cell per cycle
    typedef struct packed {
        logic                      active;
        logic                      op;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_BITS-1:0]     count;
        logic                      hit;
        logic [IDX_W-1:0]          hit_idx;
        logic                      free;
        logic [IDX_W-1:0]          free_idx;
    } t_scan;

    typedef struct packed {
        logic                      en;
        t_upd_kind                 kind;
        logic [IDX_W-1:0]          idx;
        logic signed [VALUE_W-1:0] value;
    } t_upd;

endpackage

FILE: design/mfvpt_if.sv
// request and response channel interfaces
// depends on mfvpt_pkg for field widths
interface mfvpt_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  action;
    logic signed [mfvpt_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink (input valid, input action, input value, output ready);
endinterface

interface mfvpt_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [mfvpt_pkg::STATUS_W-1:0]        status;
    logic signed [mfvpt_pkg::VALUE_W-1:0]  popped_value;

    modport source (output valid, output status, output popped_value, input ready);
    modport sink (input valid, input status, input popped_value, output ready);
endinterface

FILE: design/mfvpt_cell.sv
// one table slot: value, count and valid mark, plus one stage of the scan chain
// depends on mfvpt_pkg
module mfvpt_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [mfvpt_pkg::IDX_W-1:0]  i_idx,
    input  mfvpt_pkg::t_scan             i_tok,
    input  mfvpt_pkg::t_upd              i_upd,
    output mfvpt_pkg::t_scan             o_tok
);
    import mfvpt_pkg::*;

    logic                      r_valid;
    logic signed [VALUE_W-1:0] r_value;
    logic [COUNT_BITS-1:0]     r_count;
    t_scan                     r_tok;
    t_scan                     n_tok;
    logic                      w_sel;

    assign w_sel = i_upd.en && (i_upd.idx == i_idx);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.active) begin
            case (i_tok.op)
                ACT_INSERT: begin
                    if (!i_tok.hit) begin
                        if (r_valid && (r_value == i_tok.value)) begin
                            n_tok.hit     = 1'b1;
                            n_tok.hit_idx = i_idx;
                        end else if (!r_valid && !i_tok.free) begin
                            n_tok.free     = 1'b1;
                            n_tok.free_idx = i_idx;
                        end
                    end
                end
                ACT_POP: begin
                    if (r_valid && (!i_tok.hit || (r_count > i_tok.count) ||
                        ((r_count == i_tok.count) && (r_value > i_tok.value)))) begin
                        n_tok.hit     = 1'b1;
                        n_tok.hit_idx = i_idx;
                        n_tok.value   = r_value;
                        n_tok.count   = r_count;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (w_sel) begin
                case (i_upd.kind)
                    UPD_NEW: r_valid <= 1'b1;
                    UPD_CLR: r_valid <= 1'b0;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            case (i_upd.kind)
                UPD_NEW: begin
                    r_value <= i_upd.value;
                    r_count <= COUNT_BITS'(1);
                end
                UPD_INC: begin
                    if (r_count != {COUNT_BITS{1'b1}}) begin
                        r_count <= r_count + COUNT_BITS'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: design/most_frequent_value_pop_table_top.sv
// top level of the most frequent value pop table
// depends on mfvpt_pkg, mfvpt_req_if, mfvpt_rsp_if and mfvpt_cell
//
// channel   direction  payload
// i_req     in         action, value
// o_rsp     out        status, popped_value
//
// each request sends a token through the cell chain, one slot a cycle
// the table update and the response are applied together in S_FIN, after the token leaves
// a new request is taken while an earlier response still waits on o_rsp
// a finished request holds until the response register is free
// reset clears the valid marks and the chain at once, no clearing pass
module most_frequent_value_pop_table_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mfvpt_req_if.sink     i_req,
    mfvpt_rsp_if.source   o_rsp
);
    import mfvpt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                    r_state, n_state;
    t_scan                     r_fin;
    t_scan                     w_head;
    t_scan                     w_tok [ENTRIES+1];
    logic [ENTRIES-1:0]        w_act;
    t_upd                      w_upd;
    logic                      w_accept;
    logic                      w_commit;
    logic                      r_out_valid;
    logic [STATUS_W-1:0]       r_status, n_status;
    logic signed [VALUE_W-1:0] r_popped, n_popped;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_commit    = (r_state == S_FIN) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        w_head        = '0;
        w_head.active = w_accept;
        w_head.op     = i_req.action;
        w_head.value  = i_req.value;
    end

    assign w_tok[0] = w_head;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        mfvpt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_tok   (w_tok[g]),
            .i_upd   (w_upd),
            .o_tok   (w_tok[g+1])
        );
        assign w_act[g] = w_tok[g+1].active;
    end

    always_comb begin
        w_upd       = '0;
        w_upd.kind  = UPD_INC;
        w_upd.value = r_fin.value;
        n_status    = ST_INSERTED;
        n_popped    = '0;
        case (r_fin.op)
            ACT_INSERT: begin
                if (r_fin.hit) begin
                    w_upd.en   = w_commit;
                    w_upd.kind = UPD_INC;
                    w_upd.idx  = r_fin.hit_idx;
                end else if (r_fin.free) begin
                    w_upd.en   = w_commit;
                    w_upd.kind = UPD_NEW;
                    w_upd.idx  = r_fin.free_idx;
                end else begin
                    n_status = ST_FULL;
                end
            end
            ACT_POP: begin
                if (r_fin.hit) begin
                    w_upd.en   = w_commit;
                    w_upd.kind = UPD_CLR;
                    w_upd.idx  = r_fin.hit_idx;
                    n_status   = ST_POPPED;
                    n_popped   = r_fin.value;
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_SCAN;
            S_SCAN: if (w_tok[ENTRIES].active) n_state = S_FIN;
            S_FIN:  if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && w_tok[ENTRIES].active) begin
            r_fin <= w_tok[ENTRIES];
        end
        if (w_commit) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.popped_value = r_popped;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_act))
        else $error("more than one scan token in the chain");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |-> ($countones(w_act) == 0))
        else $error("scan token in the chain outside a scan");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN) && w_act[0])
        else $error("accepted request did not enter the chain");

    a_commit_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> o_rsp.valid && (o_rsp.status == $past(n_status)))
        else $error("finished request did not reach the response register");

    a_pop_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_POPPED)) |-> (o_rsp.popped_value == '0))
        else $error("nonzero popped value without a pop");

endmodule
